// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/lsti_pkg.sv -----
package lsti_pkg;

    localparam int IDX_W = 28;
    localparam int DIR_W = 4;
    localparam int CFG_W = 9;

    localparam logic [DIR_W-1:0] DIR_LAST  = 4'd14;
    localparam logic [CFG_W-1:0] SIZE_RST  = 9'd16;

    typedef enum logic [1:0] {
        REG_SIZE_X = 2'd0,
        REG_SIZE_Y = 2'd1,
        REG_SIZE_Z = 2'd2,
        REG_WALLS  = 2'd3
    } t_reg;

    typedef enum logic [1:0] {
        STEP_ZERO = 2'b00,
        STEP_POS  = 2'b01,
        STEP_NEG  = 2'b11
    } t_step;

    typedef struct packed {
        t_step x;
        t_step y;
        t_step z;
    } t_vel;

    // dir: direction shown on the result, slot: direction added to the index
    typedef struct packed {
        logic [DIR_W-1:0] dir;
        logic [DIR_W-1:0] slot;
        logic             bad;
        logic             last;
    } t_ctl;

    function automatic t_vel f_vel(input logic [DIR_W-1:0] d);
        t_vel v;
        v = '{x: STEP_ZERO, y: STEP_ZERO, z: STEP_ZERO};
        case (d)
            4'd1:    v = '{x: STEP_NEG,  y: STEP_ZERO, z: STEP_ZERO};
            4'd2:    v = '{x: STEP_POS,  y: STEP_ZERO, z: STEP_ZERO};
            4'd3:    v = '{x: STEP_ZERO, y: STEP_NEG,  z: STEP_ZERO};
            4'd4:    v = '{x: STEP_ZERO, y: STEP_POS,  z: STEP_ZERO};
            4'd5:    v = '{x: STEP_ZERO, y: STEP_ZERO, z: STEP_NEG};
            4'd6:    v = '{x: STEP_ZERO, y: STEP_ZERO, z: STEP_POS};
            4'd7:    v = '{x: STEP_POS,  y: STEP_POS,  z: STEP_POS};
            4'd8:    v = '{x: STEP_NEG,  y: STEP_POS,  z: STEP_POS};
            4'd9:    v = '{x: STEP_NEG,  y: STEP_NEG,  z: STEP_POS};
            4'd10:   v = '{x: STEP_POS,  y: STEP_NEG,  z: STEP_POS};
            4'd11:   v = '{x: STEP_POS,  y: STEP_POS,  z: STEP_NEG};
            4'd12:   v = '{x: STEP_NEG,  y: STEP_POS,  z: STEP_NEG};
            4'd13:   v = '{x: STEP_NEG,  y: STEP_NEG,  z: STEP_NEG};
            4'd14:   v = '{x: STEP_POS,  y: STEP_NEG,  z: STEP_NEG};
            default: v = '{x: STEP_ZERO, y: STEP_ZERO, z: STEP_ZERO};
        endcase
        return v;
    endfunction

    function automatic logic [DIR_W-1:0] f_opposite(input logic [DIR_W-1:0] d);
        logic [DIR_W-1:0] o;
        o = d;
        case (d)
            4'd1:    o = 4'd2;
            4'd2:    o = 4'd1;
            4'd3:    o = 4'd4;
            4'd4:    o = 4'd3;
            4'd5:    o = 4'd6;
            4'd6:    o = 4'd5;
            4'd7:    o = 4'd13;
            4'd8:    o = 4'd14;
            4'd9:    o = 4'd11;
            4'd10:   o = 4'd12;
            4'd11:   o = 4'd9;
            4'd12:   o = 4'd10;
            4'd13:   o = 4'd7;
            4'd14:   o = 4'd8;
            default: o = d;
        endcase
        return o;
    endfunction

endpackage

// ----- hw/rtl/lsti_seq.sv -----
module lsti_seq #(
    parameter int SW = 9
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [7:0]               i_x,
    input  logic [7:0]               i_y,
    input  logic [7:0]               i_z,
    input  logic [SW-1:0]            i_nx,
    input  logic [SW-1:0]            i_ny,
    input  logic [SW-1:0]            i_nz,
    input  logic                     i_walls,
    output logic                     o_ready,
    output logic                     o_valid,
    output lsti_pkg::t_ctl           o_ctl,
    output logic [SW-1:0]            o_x,
    output logic [SW-1:0]            o_y,
    output logic [SW-1:0]            o_z
);

    localparam int CW = (SW > 9) ? SW : 9;

    function automatic logic [CW-1:0] f_step(input logic [CW-1:0] c,
                                             input lsti_pkg::t_step d,
                                             input logic [CW-1:0] n);
        logic [CW-1:0] r;
        r = c;
        unique case (d)
            lsti_pkg::STEP_NEG:  r = (c == '0) ? n - CW'(1) : c - CW'(1);
            lsti_pkg::STEP_POS:  r = (c + CW'(1) >= n) ? '0 : c + CW'(1);
            lsti_pkg::STEP_ZERO: r = c;
            default:             r = c;
        endcase
        return r;
    endfunction

    logic                         r_busy;
    logic [lsti_pkg::DIR_W-1:0]   r_dir;
    logic [7:0]                   r_cx, r_cy, r_cz;
    logic                         r_bad;
    logic                         r_vld;
    lsti_pkg::t_ctl               r_ctl;
    logic [SW-1:0]                r_sx, r_sy, r_sz;

    logic                         w_issue, w_end, w_acc, w_in_bad;
    lsti_pkg::t_vel               w_vel;
    logic [CW-1:0]                w_xe, w_ye, w_ze, w_nxe, w_nye, w_nze;
    logic                         w_outside, w_bounce;
    logic [CW-1:0]                w_sx, w_sy, w_sz;

    assign w_issue = i_en && r_busy;
    assign w_end   = w_issue && (r_dir == lsti_pkg::DIR_LAST);
    assign o_ready = !r_busy || w_end;
    assign w_acc   = i_valid && o_ready;

    assign w_nxe = CW'(i_nx);
    assign w_nye = CW'(i_ny);
    assign w_nze = CW'(i_nz);
    assign w_in_bad = !((CW'(i_x) < w_nxe) && (CW'(i_y) < w_nye) && (CW'(i_z) < w_nze));

    assign w_vel = lsti_pkg::f_vel(r_dir);
    assign w_xe  = CW'(r_cx);
    assign w_ye  = CW'(r_cy);
    assign w_ze  = CW'(r_cz);

    assign w_outside = ((w_vel.z == lsti_pkg::STEP_NEG) && (w_ze == '0))
                    || ((w_vel.z == lsti_pkg::STEP_POS) && (w_ze + CW'(1) >= w_nze));
    assign w_bounce  = w_outside && i_walls;

    assign w_sx = w_bounce ? w_xe : f_step(w_xe, w_vel.x, w_nxe);
    assign w_sy = w_bounce ? w_ye : f_step(w_ye, w_vel.y, w_nye);
    assign w_sz = w_bounce ? w_ze : f_step(w_ze, w_vel.z, w_nze);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_dir  <= '0;
            r_vld  <= 1'b0;
        end else begin
            if (i_en) begin
                r_vld <= r_busy;
            end
            if (w_acc) begin
                r_busy <= 1'b1;
                r_dir  <= '0;
            end else if (w_end) begin
                r_busy <= 1'b0;
            end else if (w_issue) begin
                r_dir <= r_dir + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_cx  <= i_x;
            r_cy  <= i_y;
            r_cz  <= i_z;
            r_bad <= w_in_bad;
        end
        if (i_en) begin
            r_sx       <= w_sx[SW-1:0];
            r_sy       <= w_sy[SW-1:0];
            r_sz       <= w_sz[SW-1:0];
            r_ctl.dir  <= r_dir;
            r_ctl.slot <= w_bounce ? lsti_pkg::f_opposite(r_dir) : r_dir;
            r_ctl.bad  <= r_bad;
            r_ctl.last <= (r_dir == lsti_pkg::DIR_LAST);
        end
    end

    assign o_valid = r_vld;
    assign o_ctl   = r_ctl;
    assign o_x     = r_sx;
    assign o_y     = r_sy;
    assign o_z     = r_sz;

endmodule

// ----- hw/rtl/lsti_idx.sv -----
module lsti_idx #(
    parameter int SW = 9
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  lsti_pkg::t_ctl                i_ctl,
    input  logic [SW-1:0]                 i_x,
    input  logic [SW-1:0]                 i_y,
    input  logic [SW-1:0]                 i_z,
    input  logic [SW-1:0]                 i_nx,
    input  logic [SW-1:0]                 i_ny,
    output logic                          o_valid,
    output lsti_pkg::t_ctl                o_ctl,
    output logic [lsti_pkg::IDX_W-1:0]    o_index
);

    localparam int PW = 2 * SW;
    localparam int YW = 2 * SW + 1;
    localparam int LW = 3 * SW + 1;
    localparam int TW = LW + 4;
    localparam int OW = (TW > lsti_pkg::IDX_W) ? TW : lsti_pkg::IDX_W;

    logic [3:0]                 r_vld;
    lsti_pkg::t_ctl             r_ctl_a, r_ctl_b, r_ctl_c, r_ctl_d, r_ctl_e;
    logic                       r_vld_e;
    logic [PW-1:0]              r_a_zn;
    logic [SW-1:0]              r_a_x, r_a_y, r_b_x, r_c_x;
    logic [YW-1:0]              r_b_yz;
    logic [LW-1:0]              r_c_p, r_d_lin;
    logic [lsti_pkg::IDX_W-1:0] r_e_idx;

    logic [TW-1:0]              w_t;
    logic [OW-1:0]              w_te;

    assign w_t  = (TW'(r_d_lin) << 4) - TW'(r_d_lin) + TW'(r_ctl_d.slot);
    assign w_te = OW'(w_t);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_vld_e <= 1'b0;
        end else if (i_en) begin
            r_vld   <= {r_vld[2:0], i_valid};
            r_vld_e <= r_vld[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl_a <= i_ctl;
            r_a_zn  <= PW'(i_z) * PW'(i_ny);
            r_a_x   <= i_x;
            r_a_y   <= i_y;

            r_ctl_b <= r_ctl_a;
            r_b_yz  <= YW'(r_a_y) + YW'(r_a_zn);
            r_b_x   <= r_a_x;

            r_ctl_c <= r_ctl_b;
            r_c_p   <= LW'(r_b_yz) * LW'(i_nx);
            r_c_x   <= r_b_x;

            r_ctl_d <= r_ctl_c;
            r_d_lin <= r_c_p + LW'(r_c_x);

            r_ctl_e <= r_ctl_d;
            r_e_idx <= r_ctl_d.bad ? '0 : w_te[lsti_pkg::IDX_W-1:0];
        end
    end

    assign o_valid = r_vld_e;
    assign o_ctl   = r_ctl_e;
    assign o_index = r_e_idx;

endmodule

// ----- hw/rtl/lattice_stream_target_index.sv -----
// Channel   Dir  Words per cell  Contents
// s_axis    in   1               cell coordinates x, y, z
// m_axis    out  15              direction, target slot index, bad flag, last
// cfg       in   -               size_x, size_y, size_z, walls_on
//
// One direction leaves the sequencer each cycle while the output is not stalled;
// the next cell is taken on the cycle its predecessor issues direction 14.
// After issue, a direction passes the sequencer register, then index stages a to e.
// Synchronous reset restores sizes of 16, periodic z, and empties the pipeline.
// A stalled output word holds every pipeline stage; an idle sequencer still takes a cell.
`include "assert_macros.svh"

module lattice_stream_target_index #(
    parameter int MAX_SIDE = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [23:0]                   s_axis_tdata,   // cell_x, cell_y, cell_z
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [31:0]                   m_axis_tdata,   // direction, target_index
    output logic                          m_axis_tuser,   // bad_coord
    output logic                          m_axis_tlast,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [lsti_pkg::CFG_W-1:0]    i_cfg_data
);

    localparam int SW = $clog2(MAX_SIDE + 1);
    localparam int CW = (SW > lsti_pkg::CFG_W) ? SW : lsti_pkg::CFG_W;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_SIDE);

    function automatic logic [SW-1:0] f_clamp(input logic [lsti_pkg::CFG_W-1:0] s);
        logic [CW-1:0] e;
        logic [CW-1:0] r;
        e = CW'(s);
        r = (e > MAX_C) ? MAX_C : e;
        return r[SW-1:0];
    endfunction

    logic [lsti_pkg::CFG_W-1:0] r_size_x, r_size_y, r_size_z;
    logic                       r_walls;

    logic [SW-1:0]              w_nx, w_ny, w_nz;
    logic                       w_en;
    logic                       w_s1_valid;
    lsti_pkg::t_ctl             w_s1_ctl;
    logic [SW-1:0]              w_s1_x, w_s1_y, w_s1_z;
    logic                       w_o_valid;
    lsti_pkg::t_ctl             w_o_ctl;
    logic [lsti_pkg::IDX_W-1:0] w_o_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= lsti_pkg::SIZE_RST;
            r_size_y <= lsti_pkg::SIZE_RST;
            r_size_z <= lsti_pkg::SIZE_RST;
            r_walls  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (lsti_pkg::t_reg'(i_cfg_idx))
                lsti_pkg::REG_SIZE_X: r_size_x <= i_cfg_data;
                lsti_pkg::REG_SIZE_Y: r_size_y <= i_cfg_data;
                lsti_pkg::REG_SIZE_Z: r_size_z <= i_cfg_data;
                lsti_pkg::REG_WALLS:  r_walls  <= i_cfg_data[0];
            endcase
        end
    end

    assign w_nx = f_clamp(r_size_x);
    assign w_ny = f_clamp(r_size_y);
    assign w_nz = f_clamp(r_size_z);

    // advance the whole pipeline unless the output word is held
    assign w_en = !w_o_valid || m_axis_tready;

    lsti_seq #(.SW(SW)) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_axis_tvalid),
        .i_x     (s_axis_tdata[7:0]),
        .i_y     (s_axis_tdata[15:8]),
        .i_z     (s_axis_tdata[23:16]),
        .i_nx    (w_nx),
        .i_ny    (w_ny),
        .i_nz    (w_nz),
        .i_walls (r_walls),
        .o_ready (s_axis_tready),
        .o_valid (w_s1_valid),
        .o_ctl   (w_s1_ctl),
        .o_x     (w_s1_x),
        .o_y     (w_s1_y),
        .o_z     (w_s1_z)
    );

    lsti_idx #(.SW(SW)) u_idx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_s1_valid),
        .i_ctl   (w_s1_ctl),
        .i_x     (w_s1_x),
        .i_y     (w_s1_y),
        .i_z     (w_s1_z),
        .i_nx    (w_nx),
        .i_ny    (w_ny),
        .o_valid (w_o_valid),
        .o_ctl   (w_o_ctl),
        .o_index (w_o_index)
    );

    assign m_axis_tvalid = w_o_valid;
    assign m_axis_tdata  = {w_o_index, w_o_ctl.dir};
    assign m_axis_tuser  = w_o_ctl.bad;
    assign m_axis_tlast  = w_o_ctl.last;

    `ASSERT_IMPLY(a_last_dir, i_clk, i_rst_n, m_axis_tvalid,
        m_axis_tlast == (m_axis_tdata[3:0] == lsti_pkg::DIR_LAST), "last out of step")
    `ASSERT_IMPLY(a_bad_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser,
        m_axis_tdata[31:4] == '0, "bad cell gives nonzero index")
    `ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, !w_en && w_s1_valid,
        w_s1_valid && $stable(w_s1_ctl), "first stage moved during stall")

endmodule

// ----- sim/lattice_stream_target_index_tb.sv -----
`default_nettype none

module lattice_stream_target_index_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIDE_MAX    = 256;
    localparam int N_DIRS      = 15;
    localparam int SETTLE      = 12;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [lsti_pkg::DIR_W-1:0] dir;
        logic [lsti_pkg::IDX_W-1:0] idx;
        logic                       bad;
        logic                       last;
    } t_slot_word;

    typedef struct {
        int dx;
        int dy;
        int dz;
        int back;
    } t_lattice_step;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic [23:0]                s_tdata = '0;
    logic                       m_tready = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [1:0]                 cfg_idx = '0;
    logic [lsti_pkg::CFG_W-1:0] cfg_data = '0;

    logic             s_axis_tready;
    logic             m_axis_tvalid;
    logic [31:0]      m_axis_tdata;
    logic             m_axis_tuser;
    logic             m_axis_tlast;

    logic [lsti_pkg::CFG_W-1:0] grid_nx = lsti_pkg::SIZE_RST;
    logic [lsti_pkg::CFG_W-1:0] grid_ny = lsti_pkg::SIZE_RST;
    logic [lsti_pkg::CFG_W-1:0] grid_nz = lsti_pkg::SIZE_RST;
    logic                       grid_walls = 1'b0;

    t_slot_word pending_targets[$];
    bit         calm = 1'b0;
    int         errors = 0;
    int         cells_sent = 0;
    int         words_checked = 0;
    int         idle_cycles = 0;
    int         stall_left = 0;

    lattice_stream_target_index #(.MAX_SIDE(SIDE_MAX)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int side_of(input logic [lsti_pkg::CFG_W-1:0] s);
        return (s > SIDE_MAX) ? SIDE_MAX : int'(s);
    endfunction

    function automatic t_lattice_step dir_vector(input int k);
        t_lattice_step v;
        case (k)
            1:       v = '{-1,  0,  0, 2};
            2:       v = '{ 1,  0,  0, 1};
            3:       v = '{ 0, -1,  0, 4};
            4:       v = '{ 0,  1,  0, 3};
            5:       v = '{ 0,  0, -1, 6};
            6:       v = '{ 0,  0,  1, 5};
            7:       v = '{ 1,  1,  1, 13};
            8:       v = '{-1,  1,  1, 14};
            9:       v = '{-1, -1,  1, 11};
            10:      v = '{ 1, -1,  1, 12};
            11:      v = '{ 1,  1, -1, 9};
            12:      v = '{-1,  1, -1, 10};
            13:      v = '{-1, -1, -1, 7};
            14:      v = '{ 1, -1, -1, 8};
            default: v = '{ 0,  0,  0, 0};
        endcase
        return v;
    endfunction

    function automatic int step_coord(input int c, input int d, input int n);
        if (d < 0) return (c == 0) ? n - 1 : c - 1;
        if (d > 0) return (c + 1 >= n) ? 0 : c + 1;
        return c;
    endfunction

    function automatic void compute_targets(input logic [7:0] x, input logic [7:0] y,
                                            input logic [7:0] z);
        int            nx, ny, nz, xn, yn, zn;
        longint        here, tgt;
        bit            bad, outside;
        t_lattice_step v;
        t_slot_word    w;
        nx = side_of(grid_nx);
        ny = side_of(grid_ny);
        nz = side_of(grid_nz);
        bad = !(int'(x) < nx && int'(y) < ny && int'(z) < nz);
        here = 0;
        if (!bad)
            here = longint'(N_DIRS) * (longint'(x) + (longint'(y) + longint'(z) * ny) * nx);
        for (int k = 0; k < N_DIRS; k++) begin
            v = dir_vector(k);
            tgt = 0;
            if (!bad) begin
                xn = step_coord(int'(x), v.dx, nx);
                yn = step_coord(int'(y), v.dy, ny);
                outside = (v.dz < 0 && z == 0) || (v.dz > 0 && int'(z) + 1 >= nz);
                if (outside && grid_walls) begin
                    tgt = here + longint'(v.back);
                end else begin
                    zn = step_coord(int'(z), v.dz, nz);
                    tgt = longint'(N_DIRS) * (longint'(xn) + (longint'(yn)
                          + longint'(zn) * ny) * nx) + k;
                end
            end
            w.dir  = k[lsti_pkg::DIR_W-1:0];
            w.idx  = tgt[lsti_pkg::IDX_W-1:0];
            w.bad  = bad;
            w.last = (k[lsti_pkg::DIR_W-1:0] == lsti_pkg::DIR_LAST);
            pending_targets.push_back(w);
        end
    endfunction

    task automatic report(input string field, input longint exp_v, input longint act_v);
        if (exp_v != act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
        end
    endtask

    // a word seen valid and ready here is taken at the next rising edge
    always @(negedge i_clk) begin
        t_slot_word w;
        if (i_rst_n && m_axis_tvalid && m_tready) begin
            if (pending_targets.size() == 0) begin
                errors++;
                $display("%0t: unexpected word, expected none, actual dir %0d idx %0d",
                         $time, m_axis_tdata[3:0], m_axis_tdata[31:4]);
            end else begin
                w = pending_targets.pop_front();
                report("direction", w.dir, m_axis_tdata[3:0]);
                report("target_index", w.idx, m_axis_tdata[31:4]);
                report("bad_coord", w.bad, m_axis_tuser);
                report("last", w.last, m_axis_tlast);
                words_checked++;
            end
        end
        if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("lattice_stream_target_index_tb failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!calm && stall_left == 0 && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 13);
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic push_cell(input logic [7:0] x, input logic [7:0] y, input logic [7:0] z);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        @(negedge i_clk);
        while (!s_axis_tready) @(negedge i_clk);
        @(posedge i_clk);
        compute_targets(x, y, z);
        cells_sent++;
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_targets.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input lsti_pkg::t_reg idx,
                             input logic [lsti_pkg::CFG_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            lsti_pkg::REG_SIZE_X: grid_nx = val;
            lsti_pkg::REG_SIZE_Y: grid_ny = val;
            lsti_pkg::REG_SIZE_Z: grid_nz = val;
            default:              grid_walls = val[0];
        endcase
    endtask

    task automatic set_grid(input int nx, input int ny, input int nz, input bit walls);
        drain();
        write_reg(lsti_pkg::REG_SIZE_X, nx[lsti_pkg::CFG_W-1:0]);
        write_reg(lsti_pkg::REG_SIZE_Y, ny[lsti_pkg::CFG_W-1:0]);
        write_reg(lsti_pkg::REG_SIZE_Z, nz[lsti_pkg::CFG_W-1:0]);
        write_reg(lsti_pkg::REG_WALLS, {{(lsti_pkg::CFG_W-1){1'b0}}, walls});
    endtask

    function automatic logic [7:0] pick_coord(input int n);
        if (n == 0 || $urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
        if ($urandom_range(0, 2) == 0) return ($urandom_range(0, 1) != 0) ? 8'(n - 1) : 8'd0;
        return 8'($urandom_range(0, n - 1));
    endfunction

    task automatic push_random_cell;
        push_cell(pick_coord(side_of(grid_nx)), pick_coord(side_of(grid_ny)),
                  pick_coord(side_of(grid_nz)));
    endtask

    // reset grid of 16 cubed, periodic z, with corners and out-of-range cells
    task automatic test_reset_grid;
        push_cell(8'd0, 8'd0, 8'd0);
        push_cell(8'd15, 8'd15, 8'd15);
        push_cell(8'd7, 8'd0, 8'd15);
        push_cell(8'd16, 8'd0, 8'd0);
        push_cell(8'd0, 8'd16, 8'd0);
        push_cell(8'd0, 8'd0, 8'd16);
        push_cell(8'd255, 8'd255, 8'd255);
    endtask

    task automatic test_walls;
        set_grid(16, 16, 16, 1'b1);
        push_cell(8'd0, 8'd0, 8'd0);
        push_cell(8'd15, 8'd3, 8'd15);
        push_cell(8'd4, 8'd15, 8'd7);
        set_grid(5, 3, 2, 1'b1);
        push_cell(8'd4, 8'd2, 8'd0);
        push_cell(8'd0, 8'd1, 8'd1);
    endtask

    task automatic test_extremes;
        set_grid(256, 256, 256, 1'b0);
        push_cell(8'd255, 8'd255, 8'd255);
        push_cell(8'd0, 8'd0, 8'd0);
        push_cell(8'd255, 8'd0, 8'd255);
        // sizes above the maximum side behave as the maximum
        set_grid(511, 300, 257, 1'b1);
        push_cell(8'd255, 8'd255, 8'd255);
        push_cell(8'd128, 8'd0, 8'd0);
        // a zero size leaves every cell out of range
        set_grid(0, 16, 16, 1'b0);
        push_cell(8'd0, 8'd0, 8'd0);
        set_grid(16, 16, 0, 1'b1);
        push_cell(8'd3, 8'd3, 8'd0);
        // size one: every wrapped neighbour is coordinate zero
        set_grid(1, 1, 1, 1'b0);
        push_cell(8'd0, 8'd0, 8'd0);
        push_cell(8'd1, 8'd0, 8'd0);
        set_grid(1, 1, 1, 1'b1);
        push_cell(8'd0, 8'd0, 8'd0);
    endtask

    task automatic test_random_small;
        for (int phase = 0; phase < 6; phase++) begin
            set_grid($urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(1, 12),
                     1'($urandom_range(0, 1)));
            for (int i = 0; i < 40; i++) begin
                push_random_cell();
                if (i == 20) drain();
            end
        end
    endtask

    task automatic test_random_wide;
        for (int phase = 0; phase < 2; phase++) begin
            set_grid($urandom_range(0, 511), $urandom_range(180, 511),
                     $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 511),
                     1'($urandom_range(0, 1)));
            for (int i = 0; i < 25; i++)
                push_cell(8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    task automatic test_back_to_back;
        set_grid($urandom_range(1, 9), $urandom_range(1, 9), $urandom_range(1, 9), 1'b1);
        calm = 1'b1;
        for (int i = 0; i < 40; i++)
            push_random_cell();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_grid();
        test_walls();
        test_extremes();
        test_random_small();
        test_random_wide();
        test_back_to_back();
        drain();
        $display("checked %0d cells and %0d result words over periodic and walled grids,",
                 cells_sent, words_checked);
        $display("sizes from zero to beyond the maximum side, with stalls on both sides");
        if (errors == 0 && pending_targets.size() == 0) begin
            $display("lattice_stream_target_index_tb passed");
        end else begin
            $display("lattice_stream_target_index_tb failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
